/* sv/cuc_pkg.sv */
// ----------------------------------------------------------------------------
// cuc_pkg: shared types and constants for the chunked upload checker
// Item layouts, operation codes, status codes and constants.
// ----------------------------------------------------------------------------
package cuc_pkg;

  typedef enum logic [1:0] {
    FN_BEGIN  = 2'd0,
    FN_DATA   = 2'd1,
    FN_COMMIT = 2'd2
  } func_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_STATE = 3'd1,
    ST_BAD_PARAM = 3'd2,
    ST_BAD_LEN   = 3'd3,
    ST_SEQ_GAP   = 3'd4,
    ST_FLASH     = 3'd5,
    ST_CRC       = 3'd6
  } status_t;

  localparam int unsigned RECORD_BYTES  = 8;
  localparam int unsigned RECORD_SHIFT  = $clog2(RECORD_BYTES);
  localparam int unsigned REC_CNT_W     = 14;
  localparam logic [7:0]  MISSION_TYPE  = 8'd1;
  localparam logic [31:0] CRC_POLY      = 32'hEDB88320;

  typedef struct packed {
    func_t       func;
    logic [7:0]  mission_type;
    logic [31:0] body_len;
    logic [31:0] declared_crc;
    logic [15:0] seq;
    logic [15:0] chunk_len;
    logic [7:0]  data_byte;
    logic        last_of_chunk;
    logic        player_busy;
    logic        flash_error;
  } in_item_t;

  typedef struct packed {
    status_t                status;
    logic                   active_slot;
    logic                   mission_loaded;
    logic                   upload_active;
    logic [REC_CNT_W-1:0]   record_count;
  } out_item_t;

endpackage

/* sv/cuc_crc_byte.sv */
// ----------------------------------------------------------------------------
// cuc_crc_byte: one-byte CRC-32 update
// Reflected CRC-32, preset and final inversion folded in, so the running
// value starts at zero.
// ----------------------------------------------------------------------------
module cuc_crc_byte
  import cuc_pkg::*;
(
  input  logic [31:0] crc_in,
  input  logic [7:0]  data_in,
  output logic [31:0] crc_out
);

  always_comb begin
    logic [31:0] c;
    c = ~crc_in ^ {24'd0, data_in};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    crc_out = ~c;
  end

endmodule

/* sv/cuc_ctrl.sv */
// ----------------------------------------------------------------------------
// cuc_ctrl: upload state and per-item status decision
// Holds the upload/slot state, decides the status of one item and updates
// the state when the item is taken.
// ----------------------------------------------------------------------------
module cuc_ctrl
  import cuc_pkg::*;
#(
  parameter int unsigned SLOT_BYTES   = 65536,
  parameter int unsigned HEADER_BYTES = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      fire,      // item in the register is taken this cycle
  input  in_item_t  item,
  output logic      emit,      // item yields a result
  output out_item_t result
);

  localparam int unsigned MAX_LEN = SLOT_BYTES - HEADER_BYTES;
  localparam int unsigned LEN_W   = $clog2(MAX_LEN + 1);
  // byte count can run up to one saturated chunk past the declared length
  localparam int unsigned CNT_W   = $clog2(MAX_LEN + 65536);

  logic             upload_on_r,  upload_on_nxt;
  logic             target_slot_r, target_slot_nxt;
  logic [LEN_W-1:0] expected_total_r, expected_total_nxt;
  logic [CNT_W-1:0] bytes_done_r, bytes_done_nxt;
  logic [31:0]      expected_crc_r, expected_crc_nxt;
  logic [31:0]      running_crc_r, running_crc_nxt;
  logic [15:0]      next_seq_r, next_seq_nxt;
  logic [15:0]      chunk_pos_r, chunk_pos_nxt;
  status_t          chunk_status_r, chunk_status_nxt;
  logic             valid_slot_r, valid_slot_nxt;
  logic             has_mission_r, has_mission_nxt;
  logic [LEN_W-1:0] committed_len_r, committed_len_nxt;

  logic [31:0]      crc_upd;
  logic [31:0]      rc_wide;

  cuc_crc_byte u_crc (
    .crc_in  (running_crc_r),
    .data_in (item.data_byte),
    .crc_out (crc_upd)
  );

  always_comb begin
    status_t     st;
    logic [15:0] pos_inc;
    upload_on_nxt      = upload_on_r;
    target_slot_nxt    = target_slot_r;
    expected_total_nxt = expected_total_r;
    bytes_done_nxt     = bytes_done_r;
    expected_crc_nxt   = expected_crc_r;
    running_crc_nxt    = running_crc_r;
    next_seq_nxt       = next_seq_r;
    chunk_pos_nxt      = chunk_pos_r;
    chunk_status_nxt   = chunk_status_r;
    valid_slot_nxt     = valid_slot_r;
    has_mission_nxt    = has_mission_r;
    committed_len_nxt  = committed_len_r;
    emit               = 1'b0;
    st                 = ST_OK;
    pos_inc            = '0;

    unique case (item.func)
      FN_BEGIN: begin
        emit             = 1'b1;
        chunk_pos_nxt    = '0;
        chunk_status_nxt = ST_OK;
        if (item.player_busy) begin
          st = ST_BAD_STATE;
        end else if (item.mission_type != MISSION_TYPE) begin
          st = ST_BAD_PARAM;
        end else if (item.body_len == 32'd0 || item.body_len > 32'(MAX_LEN) ||
                     item.body_len[RECORD_SHIFT-1:0] != '0) begin
          st = ST_BAD_LEN;
        end else if (item.flash_error) begin
          st = ST_FLASH;
        end else begin
          target_slot_nxt    = ~valid_slot_r;
          upload_on_nxt      = 1'b1;
          expected_total_nxt = item.body_len[LEN_W-1:0];
          bytes_done_nxt     = '0;
          expected_crc_nxt   = item.declared_crc;
          running_crc_nxt    = '0;
          next_seq_nxt       = '0;
        end
      end
      FN_COMMIT: begin
        emit             = 1'b1;
        chunk_pos_nxt    = '0;
        chunk_status_nxt = ST_OK;
        if (!upload_on_r) begin
          st = ST_BAD_STATE;
        end else begin
          upload_on_nxt = 1'b0;
          if (bytes_done_r != CNT_W'(expected_total_r)) begin
            st = ST_BAD_LEN;
          end else if (item.flash_error) begin
            st = ST_FLASH;
          end else if (running_crc_r != expected_crc_r) begin
            st = ST_CRC;
          end else begin
            valid_slot_nxt    = target_slot_r;
            has_mission_nxt   = 1'b1;
            committed_len_nxt = expected_total_r;
          end
        end
      end
      FN_DATA: begin
        st = chunk_status_r;
        // first byte of a chunk: state, sequence and room checks
        if (chunk_pos_r == '0) begin
          if (!upload_on_r) begin
            st = ST_BAD_STATE;
          end else if (item.seq != next_seq_r) begin
            st = ST_SEQ_GAP;
            upload_on_nxt = 1'b0;
          end else if (item.chunk_len == '0 ||
                       33'(bytes_done_r) + 33'(item.chunk_len) > 33'(expected_total_r)) begin
            st = ST_BAD_LEN;
            upload_on_nxt = 1'b0;
          end else begin
            st = ST_OK;
          end
        end
        if (st == ST_OK) begin
          if (chunk_pos_r >= item.chunk_len) begin
            st = ST_BAD_LEN;
            upload_on_nxt = 1'b0;
          end else if (item.flash_error) begin
            st = ST_FLASH;
            upload_on_nxt = 1'b0;
          end else begin
            running_crc_nxt = crc_upd;
            bytes_done_nxt  = bytes_done_r + CNT_W'(1);
          end
        end
        pos_inc = (chunk_pos_r != 16'hFFFF) ? chunk_pos_r + 16'd1 : chunk_pos_r;
        if (item.last_of_chunk) begin
          emit = 1'b1;
          if (st == ST_OK && pos_inc != item.chunk_len) begin
            st = ST_BAD_LEN;
            upload_on_nxt = 1'b0;
          end
          if (st == ST_OK) begin
            next_seq_nxt = next_seq_r + 16'd1;
          end
          chunk_pos_nxt    = '0;
          chunk_status_nxt = ST_OK;
        end else begin
          chunk_pos_nxt    = pos_inc;
          chunk_status_nxt = st;
        end
      end
      default: begin
        // reserved code: no result, no change
      end
    endcase

    rc_wide = has_mission_nxt ? (32'(committed_len_nxt) >> RECORD_SHIFT) : 32'd0;
    result.status         = st;
    result.active_slot    = valid_slot_nxt;
    result.mission_loaded = has_mission_nxt;
    result.upload_active  = upload_on_nxt;
    result.record_count   = rc_wide[REC_CNT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upload_on_r      <= 1'b0;
      target_slot_r    <= 1'b0;
      expected_total_r <= '0;
      bytes_done_r     <= '0;
      expected_crc_r   <= '0;
      running_crc_r    <= '0;
      next_seq_r       <= '0;
      chunk_pos_r      <= '0;
      chunk_status_r   <= ST_OK;
      valid_slot_r     <= 1'b0;
      has_mission_r    <= 1'b0;
      committed_len_r  <= '0;
    end else if (fire) begin
      upload_on_r      <= upload_on_nxt;
      target_slot_r    <= target_slot_nxt;
      expected_total_r <= expected_total_nxt;
      bytes_done_r     <= bytes_done_nxt;
      expected_crc_r   <= expected_crc_nxt;
      running_crc_r    <= running_crc_nxt;
      next_seq_r       <= next_seq_nxt;
      chunk_pos_r      <= chunk_pos_nxt;
      chunk_status_r   <= chunk_status_nxt;
      valid_slot_r     <= valid_slot_nxt;
      has_mission_r    <= has_mission_nxt;
      committed_len_r  <= committed_len_nxt;
    end
  end

  // an upload is only armed by a taken begin item
  a_arm_by_begin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(upload_on_r) |-> $past(fire && item.func == FN_BEGIN))
    else $error("upload armed without a begin item");

  // once committed, a mission stays loaded
  a_mission_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    has_mission_r |=> has_mission_r)
    else $error("mission_loaded dropped");

  // between chunks there is no pending chunk status
  a_idle_pos_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (chunk_pos_r == '0) |-> (chunk_status_r == ST_OK))
    else $error("chunk status left over outside a chunk");

endmodule

/* sv/chunked_upload_checker.sv */
// ----------------------------------------------------------------------------
// chunked_upload_checker: A/B slot chunked upload receiver with CRC-32 check
// Begin, chunk bytes and commit arrive as items; status results come out on
// begin, commit and the last byte of each chunk.
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+----------------------------
//  in_     | in  | in_valid/in_stall  | in_item  (in_item_t)
//  out_    | out | out_valid/out_stall| out_item (out_item_t)
//
//  One item per cycle sustained unless in_stall holds the input. An item
//  sits in the input register, where the status decision and the
//  byte-wide CRC update run, and its result lands in the output register.
//  Items without a result (middle chunk bytes, reserved codes) retire
//  without touching the output register.
//  Reset (rst_n low, synchronous) clears all upload and slot state.
//  out_stall holds the output register; in_stall rises only when the
//  item in the input register has a result and the output register is
//  full and held by out_stall.
//
module chunked_upload_checker
  import cuc_pkg::*;
#(
  parameter int unsigned SLOT_BYTES   = 65536,
  parameter int unsigned HEADER_BYTES = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  // input register
  logic      s1_valid_r, s1_valid_nxt;
  in_item_t  s1_item_r;

  // output register
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_item_r;

  logic      emit;
  out_item_t result;
  logic      advance;   // input register item retires this cycle

  cuc_ctrl #(
    .SLOT_BYTES   (SLOT_BYTES),
    .HEADER_BYTES (HEADER_BYTES)
  ) u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (advance),
    .item   (s1_item_r),
    .emit   (emit),
    .result (result)
  );

  // an item retires unless it has a result and the output slot stays full
  assign advance  = s1_valid_r && (!emit || !out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !advance;

  always_comb begin
    s1_valid_nxt  = in_stall ? s1_valid_r : in_valid;
    out_valid_nxt = (out_valid_r && out_stall) || (advance && emit);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_item_r <= in_item;
    end
    if (advance && emit) begin
      out_item_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // back-pressure only with an item waiting in the input register
  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r)
    else $error("in_stall with empty input register");

  // a result never overwrites one still held by out_stall
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |-> !(advance && emit))
    else $error("held result overwritten");

  // a retired result-bearing item shows up at the output next cycle
  a_result_shown: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && emit) |=> out_valid_r)
    else $error("result lost");

endmodule

/* tb/chunked_upload_checker_tb.sv */
// ----------------------------------------------------------------------------
// chunked_upload_checker_tb: self-checking bench for the chunked upload checker
// Feeds begin, chunk byte and commit items with random idle on both channels,
// predicts each status result from a behavioral copy of the upload state and
// compares every result field against the oldest prediction.
// ----------------------------------------------------------------------------
module chunked_upload_checker_tb;
  import cuc_pkg::*;

  localparam int unsigned SLOT_BYTES   = 65536;
  localparam int unsigned HEADER_BYTES = 32;
  localparam int unsigned MAX_BODY     = SLOT_BYTES - HEADER_BYTES;
  localparam func_t       FN_RESERVED  = func_t'(2'd3);
  localparam int          RANDOM_ITEMS = 400;
  localparam int          RESET_CYCLES = 7;
  localparam int          DRAIN_CYCLES = 16;
  localparam int          STALL_LIMIT  = 2000;
  localparam int          HOLD_AT      = 60;
  localparam int          HOLD_CYCLES  = 200;
  localparam int          MAX_REPORTS  = 10;

  // ways a generated upload goes wrong
  typedef enum int {
    UF_NONE,
    UF_FLASH_BYTE,
    UF_SEQ,
    UF_LEN_TWIST,
    UF_CHUNK_SIZE,
    UF_CRC,
    UF_EARLY_COMMIT,
    UF_FLASH_COMMIT,
    UF_ABANDON,
    UF_OVERRUN,
    UF_BUSY_BEGIN
  } upload_fault_t;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_item   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;

  chunked_upload_checker #(
    .SLOT_BYTES  (SLOT_BYTES),
    .HEADER_BYTES(HEADER_BYTES)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item)
  );

  always #4 clk = ~clk;

  // --------------------------------------------------------------------------
  // Predicted upload state
  // --------------------------------------------------------------------------
  logic        up_on = 1'b0, tgt_slot = 1'b0, cur_slot = 1'b0, loaded = 1'b0;
  int unsigned exp_total = 0, done_bytes = 0, commit_len = 0;
  logic [31:0] exp_crc = '0, run_crc = '0;
  logic [15:0] want_seq = '0, pos_in_chunk = '0;
  status_t     chunk_st = ST_OK;

  in_item_t    pending_items[$];
  out_item_t   status_due[$];
  logic [7:0]  body_bytes[$];
  int          stim_count = 0;

  function automatic logic [31:0] crc32_step(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = ~crc ^ {24'd0, b};
    for (int i = 0; i < 8; i++) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    return ~c;
  endfunction

  function automatic logic [31:0] body_crc();
    logic [31:0] c;
    c = '0;
    foreach (body_bytes[i]) c = crc32_step(c, body_bytes[i]);
    return c;
  endfunction

  function automatic out_item_t result_word(input status_t st);
    out_item_t r;
    r.status         = st;
    r.active_slot    = cur_slot;
    r.mission_loaded = loaded;
    r.upload_active  = up_on;
    r.record_count   = loaded ? REC_CNT_W'(commit_len / RECORD_BYTES) : '0;
    return r;
  endfunction

  // Advances the predicted state by one item; returns 1 when it yields a status.
  function automatic bit next_status(input in_item_t it, output out_item_t res);
    status_t st;
    res = '0;
    case (it.func)
      FN_BEGIN: begin
        pos_in_chunk = '0;
        chunk_st     = ST_OK;
        if (it.player_busy) st = ST_BAD_STATE;
        else if (it.mission_type != MISSION_TYPE) st = ST_BAD_PARAM;
        else if (it.body_len == 0 || it.body_len > MAX_BODY) st = ST_BAD_LEN;
        else if (it.body_len % RECORD_BYTES != 0) st = ST_BAD_LEN;
        else if (it.flash_error) st = ST_FLASH;
        else begin
          st         = ST_OK;
          tgt_slot   = ~cur_slot;
          up_on      = 1'b1;
          exp_total  = it.body_len;
          done_bytes = 0;
          exp_crc    = it.declared_crc;
          run_crc    = '0;
          want_seq   = '0;
        end
        res = result_word(st);
        return 1'b1;
      end
      FN_COMMIT: begin
        pos_in_chunk = '0;
        chunk_st     = ST_OK;
        if (!up_on) st = ST_BAD_STATE;
        else begin
          up_on = 1'b0;
          if (done_bytes != exp_total) st = ST_BAD_LEN;
          else if (it.flash_error) st = ST_FLASH;
          else if (run_crc != exp_crc) st = ST_CRC;
          else begin
            st         = ST_OK;
            cur_slot   = tgt_slot;
            loaded     = 1'b1;
            commit_len = exp_total;
          end
        end
        res = result_word(st);
        return 1'b1;
      end
      FN_DATA: begin
        // first byte of a chunk decides state, sequence and length
        if (pos_in_chunk == 0) begin
          if (!up_on) chunk_st = ST_BAD_STATE;
          else if (it.seq != want_seq) begin
            chunk_st = ST_SEQ_GAP;
            up_on    = 1'b0;
          end else if (it.chunk_len == 0 || done_bytes + it.chunk_len > exp_total) begin
            chunk_st = ST_BAD_LEN;
            up_on    = 1'b0;
          end else chunk_st = ST_OK;
        end
        if (chunk_st == ST_OK) begin
          if (pos_in_chunk >= it.chunk_len) begin
            chunk_st = ST_BAD_LEN;
            up_on    = 1'b0;
          end else if (it.flash_error) begin
            chunk_st = ST_FLASH;
            up_on    = 1'b0;
          end else begin
            run_crc = crc32_step(run_crc, it.data_byte);
            done_bytes++;
          end
        end
        if (pos_in_chunk != 16'hFFFF) pos_in_chunk++;
        if (!it.last_of_chunk) return 1'b0;
        // short chunk: last byte came before chunk_len bytes
        if (chunk_st == ST_OK && pos_in_chunk != it.chunk_len) begin
          chunk_st = ST_BAD_LEN;
          up_on    = 1'b0;
        end
        st = chunk_st;
        if (st == ST_OK) want_seq++;
        pos_in_chunk = '0;
        chunk_st     = ST_OK;
        res = result_word(st);
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus builders
  // --------------------------------------------------------------------------
  function automatic in_item_t rand_item(input func_t f);
    in_item_t it;
    it.func          = f;
    it.mission_type  = 8'($urandom);
    it.body_len      = $urandom;
    it.declared_crc  = $urandom;
    it.seq           = 16'($urandom);
    it.chunk_len     = 16'($urandom);
    it.data_byte     = 8'($urandom);
    it.last_of_chunk = 1'($urandom);
    it.player_busy   = 1'($urandom);
    it.flash_error   = 1'($urandom);
    return it;
  endfunction

  task automatic push_item(input in_item_t it);
    pending_items.push_back(it);
    if (it.func != FN_RESERVED) stim_count++;
  endtask

  task automatic push_reserved();
    push_item(rand_item(FN_RESERVED));
  endtask

  task automatic push_begin(input logic [7:0] mtype, input logic [31:0] tlen,
                            input logic [31:0] dcrc, input bit busy, input bit ferr);
    in_item_t it;
    it              = rand_item(FN_BEGIN);
    it.mission_type = mtype;
    it.body_len     = tlen;
    it.declared_crc = dcrc;
    it.player_busy  = busy;
    it.flash_error  = ferr;
    push_item(it);
  endtask

  task automatic push_commit(input bit ferr);
    in_item_t it;
    it             = rand_item(FN_COMMIT);
    it.flash_error = ferr;
    push_item(it);
  endtask

  // Chunk bytes come from body_bytes while any are left, else random.
  task automatic push_chunk(input logic [15:0] seq, input logic [15:0] clen, input int nbytes,
                            input int ferr_at, input int twist_at, input bit with_last);
    in_item_t it;
    for (int i = 0; i < nbytes; i++) begin
      it = rand_item(FN_DATA);
      // seq only matters on the first byte
      it.seq           = (i == 0 || $urandom_range(0, 1)) ? seq : 16'($urandom);
      it.chunk_len     = (i == twist_at) ? 16'($urandom) : clen;
      it.data_byte     = (body_bytes.size() != 0) ? body_bytes.pop_front() : 8'($urandom);
      it.flash_error   = (i == ferr_at);
      it.last_of_chunk = with_last && (i == nbytes - 1);
      push_item(it);
      if ($urandom_range(0, 49) == 0) push_reserved();
    end
  endtask

  // Well-formed upload with random content, sometimes broken on purpose.
  task automatic gen_upload(input int nrec);
    int unsigned   total, left, clen;
    upload_fault_t fault;
    logic [15:0]   seq_no;
    logic [31:0]   crc;
    bit            fired;
    total = nrec * RECORD_BYTES;
    body_bytes.delete();
    repeat (total) body_bytes.push_back($urandom_range(0, 3) == 0 ? 8'hFF : 8'($urandom));
    crc   = body_crc();
    fault = ($urandom_range(0, 99) < 55) ? UF_NONE : upload_fault_t'($urandom_range(1, 10));
    push_begin(MISSION_TYPE, total,
               (fault == UF_CRC) ? crc ^ (32'h1 << $urandom_range(0, 31)) : crc, 1'b0, 1'b0);
    left   = total;
    seq_no = '0;
    fired  = 1'b0;
    while (left > 0) begin
      clen = $urandom_range(1, (left < 24) ? left : 24);
      if (fault == UF_BUSY_BEGIN && $urandom_range(0, 1)) begin
        // refused begin between chunks must leave the upload alone
        push_begin(MISSION_TYPE, 32'd16, $urandom, 1'b1, 1'($urandom_range(0, 1)));
        fault = UF_NONE;
      end
      if (fault inside {UF_FLASH_BYTE, UF_SEQ, UF_LEN_TWIST, UF_CHUNK_SIZE, UF_EARLY_COMMIT,
                        UF_ABANDON, UF_OVERRUN} && ($urandom_range(0, 2) == 0 || clen == left)) begin
        fired = 1'b1;
        case (fault)
          UF_FLASH_BYTE: push_chunk(seq_no, 16'(clen), clen, $urandom_range(0, clen - 1), -1,
                                    1'b1);
          UF_SEQ:        push_chunk(seq_no + 16'($urandom_range(1, 65535)), 16'(clen), clen,
                                    -1, -1, 1'b1);
          UF_LEN_TWIST:  push_chunk(seq_no, 16'(clen), clen, -1, $urandom_range(0, clen - 1),
                                    1'b1);
          UF_CHUNK_SIZE: push_chunk(seq_no, 16'(clen),
                                    (clen > 1 && $urandom_range(0, 1)) ? clen - 1 : clen + 1,
                                    -1, -1, 1'b1);
          UF_ABANDON:    push_chunk(seq_no, 16'(clen), $urandom_range(1, clen), -1, -1, 1'b0);
          UF_OVERRUN:    push_chunk(seq_no, 16'(left + $urandom_range(1, 64)),
                                    $urandom_range(1, 4), -1, -1, 1'b1);
          default: ;
        endcase
        break;
      end
      push_chunk(seq_no, 16'(clen), clen, -1, -1, 1'b1);
      seq_no++;
      left -= clen;
    end
    // an abandoned chunk is left open for whatever item follows
    if (!(fired && fault == UF_ABANDON)) push_commit(fault == UF_FLASH_COMMIT);
  endtask

  // Loose items with mostly random fields.
  task automatic gen_noise();
    logic [31:0] tlen;
    case ($urandom_range(0, 3))
      0: begin
        case ($urandom_range(0, 3))
          0: tlen = $urandom;
          1: tlen = $urandom_range(0, 65535);
          2: tlen = RECORD_BYTES * $urandom_range(1, MAX_BODY / RECORD_BYTES);
          default: tlen = MAX_BODY + RECORD_BYTES * $urandom_range(0, 4);
        endcase
        push_begin($urandom_range(0, 1) ? MISSION_TYPE : 8'($urandom), tlen, $urandom,
                   $urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0);
      end
      1: push_chunk($urandom_range(0, 1) ? 16'($urandom_range(0, 3)) : 16'($urandom),
                    $urandom_range(0, 1) ? 16'($urandom_range(0, 8)) : 16'($urandom),
                    $urandom_range(1, 4), ($urandom_range(0, 5) == 0) ? 0 : -1, -1,
                    $urandom_range(0, 3) != 0);
      2: push_commit($urandom_range(0, 3) == 0);
      default: push_reserved();
    endcase
  endtask

  // Idle lengths: mostly none or short, now and then long; zero in calm stretches.
  function automatic int draw_idle(input bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // --------------------------------------------------------------------------
  // Driver: offers queued items, predicts on acceptance
  // --------------------------------------------------------------------------
  int        in_gap  = 0;
  bit        in_calm = 1'b0;
  bit        in_took;
  out_item_t predicted;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      in_took = in_valid && !in_stall;
      if (in_took) begin
        if (next_status(in_item, predicted)) status_due.push_back(predicted);
        if ($urandom_range(0, 63) == 0) in_calm = !in_calm;
      end
      if (!in_valid || in_took) begin
        if (in_gap != 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (pending_items.size() != 0) begin
          in_item  <= pending_items.pop_front();
          in_valid <= 1'b1;
          in_gap   = draw_idle(in_calm);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: random stall, one long hold, field compare
  // --------------------------------------------------------------------------
  int        stall_left   = 0;
  int        hold_left    = 0;
  bit        hold_done    = 1'b0;
  bit        out_calm     = 1'b0;
  int        results_seen = 0;
  int        fail_count   = 0;
  out_item_t want;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (status_due.size() == 0) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("unexpected result: status %0d slot %0b loaded %0b active %0b records %0d",
                     out_item.status, out_item.active_slot, out_item.mission_loaded,
                     out_item.upload_active, out_item.record_count);
        end else begin
          want = status_due.pop_front();
          if (out_item.status !== want.status || out_item.active_slot !== want.active_slot ||
              out_item.mission_loaded !== want.mission_loaded ||
              out_item.upload_active !== want.upload_active ||
              out_item.record_count !== want.record_count) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
              $display({"result %0d mismatch: exp status %0d slot %0b loaded %0b active %0b ",
                        "records %0d, got status %0d slot %0b loaded %0b active %0b records %0d"},
                       results_seen, want.status, want.active_slot, want.mission_loaded,
                       want.upload_active, want.record_count, out_item.status,
                       out_item.active_slot, out_item.mission_loaded, out_item.upload_active,
                       out_item.record_count);
          end
        end
        if ($urandom_range(0, 63) == 0) out_calm = !out_calm;
      end
      // one long hold so the block backs up and stalls its input
      if (!hold_done && results_seen >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (stall_left != 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall  <= 1'b0;
        stall_left = ($urandom_range(0, 2) == 0) ? draw_idle(out_calm) : 0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: too long without any item moving
  // --------------------------------------------------------------------------
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("[chunked_upload_checker] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    int          base;
    logic [31:0] crc;

    // directed: refusals, idle chunk and commit, reserved code, one clean upload
    push_commit(1'b0);
    push_chunk(16'd0, 16'd1, 1, -1, -1, 1'b1);
    push_begin(MISSION_TYPE, 32'd8, 32'd0, 1'b1, 1'b0);
    push_begin(8'd0, 32'd8, 32'd0, 1'b0, 1'b0);
    push_begin(8'hFF, 32'd8, 32'd0, 1'b0, 1'b0);
    push_begin(MISSION_TYPE, 32'd0, 32'd0, 1'b0, 1'b0);
    push_begin(MISSION_TYPE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b0);
    push_begin(MISSION_TYPE, MAX_BODY + RECORD_BYTES, 32'd0, 1'b0, 1'b0);
    push_begin(MISSION_TYPE, 32'd12, 32'd0, 1'b0, 1'b0);
    push_begin(MISSION_TYPE, MAX_BODY, 32'd0, 1'b0, 1'b1);
    push_reserved();
    body_bytes = {8'h00, 8'hFF, 8'h5A, 8'hA5, 8'h01, 8'h80, 8'h7F, 8'hFE};
    crc = body_crc();
    push_begin(MISSION_TYPE, 32'd8, crc, 1'b0, 1'b0);
    push_chunk(16'd0, 16'd8, 8, -1, -1, 1'b1);
    push_commit(1'b0);

    // longest body is accepted; a commit with no bytes is a length error
    push_begin(MISSION_TYPE, MAX_BODY, 32'd0, 1'b0, 1'b0);
    push_commit(1'b0);

    // seq gap held across the rest of the chunk
    push_begin(MISSION_TYPE, 32'd8, 32'd0, 1'b0, 1'b0);
    push_chunk(16'd7, 16'($urandom), 8, -1, -1, 1'b1);
    push_commit(1'b0);

    base = stim_count;
    while (stim_count - base < RANDOM_ITEMS) begin
      if ($urandom_range(0, 3) != 0)
        gen_upload(($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 6));
      else
        gen_noise();
    end

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_items.size() != 0 || in_valid || status_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0 && status_due.size() == 0)
      $display("[chunked_upload_checker] OK");
    else
      $display("[chunked_upload_checker] ERROR");
    $finish;
  end

endmodule
